// ----- design/idll_pkg.sv -----
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types and constants for the indexed doubly linked list.
// ----------------------------------------------------------------------------
package idll_pkg;

    localparam int KEY_W     = 10;
    localparam int FUNC_W    = 3;
    localparam int OUT_W     = 11;
    localparam int SLOTS_DEF = 1024;

    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_BEFORE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_AFTER   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd5;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_APPEND,
        OP_PREPEND,
        OP_BEFORE,
        OP_AFTER,
        OP_REMOVE,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] anchor;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WR1,
        BK_WR2
    } t_back_state;

endpackage

// ----- design/indexed_doubly_linked_list.sv -----
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Doubly linked list over a fixed set of key slots with head, tail and count.
// ----------------------------------------------------------------------------
// sequence: an accepted request waits in the queue, is popped with its link
//   read, then written to the link stores in WR1 and WR2 before its result strobe
// requests: the back takes a new request only once the link writes of the last
//   one are done in WR1 and WR2; a 2-entry queue absorbs bursts
// reset: busy stays high after reset while the link stores are swept to empty;
//   the result receiver cannot stall
module indexed_doubly_linked_list import idll_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [KEY_W-1:0]        i_key,
    input  logic [KEY_W-1:0]        i_anchor_key,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_head_key,
    output logic signed [OUT_W-1:0] o_tail_key,
    output logic [OUT_W-1:0]        o_element_count
);

    t_cmd             push_cmd;
    t_cmd             head_cmd;
    logic             push;
    logic             pop;
    t_q_status        q_status;
    t_back_status     back_status;
    logic [OUT_W-1:0] head_key;
    logic [OUT_W-1:0] tail_key;

    idll_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_key        (i_key),
        .i_anchor_key (i_anchor_key),
        .i_q_status   (q_status),
        .i_back_status(back_status),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    idll_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_status(q_status)
    );

    idll_back #(
        .SLOTS(SLOTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_status       (back_status),
        .o_valid        (o_valid),
        .o_head_key     (head_key),
        .o_tail_key     (tail_key),
        .o_element_count(o_element_count)
    );

    assign o_head_key = $signed(head_key);
    assign o_tail_key = $signed(tail_key);

endmodule

// ----- design/idll_front.sv -----
// ----------------------------------------------------------------------------
// idll_front
// Accepts requests, range checks key and anchor and decodes the operation.
// ----------------------------------------------------------------------------
module idll_front import idll_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [KEY_W-1:0]   i_anchor_key,
    input  t_q_status          i_q_status,
    input  t_back_status       i_back_status,
    output logic               o_push,
    output t_cmd               o_cmd
);

    localparam int CMP_W = KEY_W + $clog2(SLOTS) + 1;

    logic key_ok;
    logic anc_ok;
    t_op  op;

    assign key_ok = CMP_W'(i_key) < CMP_W'(SLOTS);
    assign anc_ok = CMP_W'(i_anchor_key) < CMP_W'(SLOTS);

    always_comb begin
        case (i_func)
            FUNC_APPEND:  op = key_ok ? OP_APPEND : OP_NOP;
            FUNC_PREPEND: op = key_ok ? OP_PREPEND : OP_NOP;
            FUNC_BEFORE:  op = (key_ok && anc_ok) ? OP_BEFORE : OP_NOP;
            FUNC_AFTER:   op = (key_ok && anc_ok) ? OP_AFTER : OP_NOP;
            FUNC_REMOVE:  op = key_ok ? OP_REMOVE : OP_NOP;
            FUNC_CLEAR:   op = OP_CLEAR;
            default:      op = OP_NOP;
        endcase
    end

    // hold requests off while the queue is full or the link store is being initialised
    assign busy   = i_q_status.full | i_back_status.clearing;
    assign o_push = start & ~busy;

    assign o_cmd.op     = op;
    assign o_cmd.key    = i_key;
    assign o_cmd.anchor = i_anchor_key;

endmodule

// ----- design/idll_queue.sv -----
// ----------------------------------------------------------------------------
// idll_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module idll_queue import idll_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_cmd          r_entry [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [PW:0]   r_fill;
    logic [PW:0]   n_fill;

    always_comb begin
        n_wr_ptr = i_push ? PW'(r_wr_ptr + PW'(1)) : r_wr_ptr;
        n_rd_ptr = i_pop ? PW'(r_rd_ptr + PW'(1)) : r_rd_ptr;
        n_fill   = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + (PW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_entry[r_rd_ptr];
    assign o_status.full  = (r_fill == (PW+1)'(DEPTH));
    assign o_status.empty = (r_fill == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_fill == (PW+1)'(DEPTH))))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_fill == '0)))
        else $error("command queue read while empty");

endmodule

// ----- design/idll_back.sv -----
// ----------------------------------------------------------------------------
// idll_back
// Carries out list operations on the link stores and reports head/tail/count.
// ----------------------------------------------------------------------------
module idll_back import idll_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    output t_back_status      o_status,
    output logic              o_valid,
    output logic [OUT_W-1:0]  o_head_key,
    output logic [OUT_W-1:0]  o_tail_key,
    output logic [OUT_W-1:0]  o_element_count
);

    localparam int AW = $clog2(SLOTS);
    localparam int LW = AW + 1;
    localparam int CW = $clog2(SLOTS + 1);

    // link: top bit set means no element
    localparam logic [LW-1:0] LINK_NONE = {LW{1'b1}};

    t_back_state r_state;
    t_back_state n_state;

    logic [LW-1:0] m_prev [SLOTS];
    logic [LW-1:0] m_next [SLOTS];
    logic [LW-1:0] r_rd_prev;
    logic [LW-1:0] r_rd_next;

    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] n_clr_addr;
    t_op           r_op;
    logic [AW-1:0] r_key;
    logic [AW-1:0] r_anc;

    logic [LW-1:0] r_head;
    logic [LW-1:0] n_head;
    logic [LW-1:0] r_tail;
    logic [LW-1:0] n_tail;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic             r_valid;
    logic [OUT_W-1:0] r_head_key;
    logic [OUT_W-1:0] r_tail_key;
    logic [OUT_W-1:0] r_element_count;

    logic          pop;
    logic          we_p;
    logic [AW-1:0] wa_p;
    logic [LW-1:0] wd_p;
    logic          we_n;
    logic [AW-1:0] wa_n;
    logic [LW-1:0] wd_n;
    logic [AW-1:0] ra_p;
    logic [AW-1:0] ra_n;

    logic          head_none;
    logic          tail_none;
    logic          p_none;
    logic          n_none;
    logic [LW-1:0] key_link;
    logic [LW-1:0] anc_link;
    logic [CW-1:0] count_up;
    logic [CW-1:0] count_down;

    assign head_none  = r_head[AW];
    assign tail_none  = r_tail[AW];
    assign p_none     = r_rd_prev[AW];
    assign n_none     = r_rd_next[AW];
    assign key_link   = {1'b0, r_key};
    assign anc_link   = {1'b0, r_anc};
    assign count_up   = (r_count != CW'(SLOTS)) ? r_count + CW'(1) : r_count;
    assign count_down = (r_count != '0) ? r_count - CW'(1) : r_count;

    // next state
    always_comb begin
        case (r_state)
            BK_CLEAR: n_state = (r_clr_addr == AW'(SLOTS - 1)) ? BK_IDLE : BK_CLEAR;
            BK_IDLE:  n_state = i_q_status.empty ? BK_IDLE : BK_WR1;
            BK_WR1:   n_state = BK_WR2;
            BK_WR2:   n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // outputs: pop, link reads and writes
    always_comb begin
        pop  = 1'b0;
        we_p = 1'b0;
        wa_p = r_key;
        wd_p = LINK_NONE;
        we_n = 1'b0;
        wa_n = r_key;
        wd_n = LINK_NONE;
        o_status.clearing = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                o_status.clearing = 1'b1;
                we_p = 1'b1;
                wa_p = r_clr_addr;
                we_n = 1'b1;
                wa_n = r_clr_addr;
            end
            BK_IDLE: begin
                pop = ~i_q_status.empty;
            end
            BK_WR1: begin
                case (r_op)
                    OP_APPEND: begin
                        we_p = 1'b1;
                        wd_p = r_tail;
                        we_n = ~tail_none;
                        wa_n = r_tail[AW-1:0];
                        wd_n = key_link;
                    end
                    OP_PREPEND: begin
                        we_n = 1'b1;
                        wd_n = r_head;
                        we_p = ~head_none;
                        wa_p = r_head[AW-1:0];
                        wd_p = key_link;
                    end
                    OP_BEFORE: begin
                        we_p = 1'b1;
                        wd_p = r_rd_prev;
                        we_n = 1'b1;
                        wd_n = anc_link;
                    end
                    OP_AFTER: begin
                        we_p = 1'b1;
                        wd_p = anc_link;
                        we_n = 1'b1;
                        wd_n = r_rd_next;
                    end
                    OP_REMOVE: begin
                        // unlink: neighbours point past the removed key
                        we_p = ~n_none;
                        wa_p = r_rd_next[AW-1:0];
                        wd_p = r_rd_prev;
                        we_n = ~p_none;
                        wa_n = r_rd_prev[AW-1:0];
                        wd_n = r_rd_next;
                    end
                    default: begin
                    end
                endcase
            end
            BK_WR2: begin
                case (r_op)
                    OP_APPEND: begin
                        we_n = 1'b1;
                    end
                    OP_PREPEND: begin
                        we_p = 1'b1;
                    end
                    OP_BEFORE: begin
                        we_p = 1'b1;
                        wa_p = r_anc;
                        wd_p = key_link;
                        we_n = ~p_none;
                        wa_n = r_rd_prev[AW-1:0];
                        wd_n = key_link;
                    end
                    OP_AFTER: begin
                        we_n = 1'b1;
                        wa_n = r_anc;
                        wd_n = key_link;
                        we_p = ~n_none;
                        wa_p = r_rd_next[AW-1:0];
                        wd_p = key_link;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // head, tail and count after the operation, settled in the first write cycle
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (r_state == BK_WR1) begin
            case (r_op)
                OP_APPEND: begin
                    n_tail  = key_link;
                    n_head  = tail_none ? key_link : r_head;
                    n_count = count_up;
                end
                OP_PREPEND: begin
                    n_head  = key_link;
                    n_tail  = head_none ? key_link : r_tail;
                    n_count = count_up;
                end
                OP_BEFORE: begin
                    n_head  = p_none ? key_link : r_head;
                    n_count = count_up;
                end
                OP_AFTER: begin
                    n_tail  = n_none ? key_link : r_tail;
                    n_count = count_up;
                end
                OP_REMOVE: begin
                    if (p_none) begin
                        n_head = r_rd_next;
                    end
                    if (n_none) begin
                        n_tail = r_rd_prev;
                    end
                    n_count = count_down;
                end
                OP_CLEAR: begin
                    n_head  = LINK_NONE;
                    n_tail  = LINK_NONE;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_clr_addr = AW'(r_clr_addr + AW'(1));
    assign ra_p = (i_cmd.op == OP_BEFORE) ? AW'(i_cmd.anchor) : AW'(i_cmd.key);
    assign ra_n = (i_cmd.op == OP_AFTER) ? AW'(i_cmd.anchor) : AW'(i_cmd.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
            r_head     <= LINK_NONE;
            r_tail     <= LINK_NONE;
            r_count    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= n_clr_addr;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_valid <= (r_state == BK_WR2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_op  <= i_cmd.op;
            r_key <= AW'(i_cmd.key);
            r_anc <= AW'(i_cmd.anchor);
        end
        if (r_state == BK_WR2) begin
            r_head_key      <= head_none ? '1 : OUT_W'(r_head[AW-1:0]);
            r_tail_key      <= tail_none ? '1 : OUT_W'(r_tail[AW-1:0]);
            r_element_count <= OUT_W'(r_count);
        end
    end

    // link stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (we_p) begin
            m_prev[wa_p] <= wd_p;
        end
        if (pop) begin
            r_rd_prev <= m_prev[ra_p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_n) begin
            m_next[wa_n] <= wd_n;
        end
        if (pop) begin
            r_rd_next <= m_next[ra_n];
        end
    end

    assign o_pop           = pop;
    assign o_valid         = r_valid;
    assign o_head_key      = r_head_key;
    assign o_tail_key      = r_tail_key;
    assign o_element_count = r_element_count;

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for more than one cycle");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("element count above slot count");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CLEAR) |-> !pop)
        else $error("request taken during link store initialisation");

endmodule

// ----- tb/idll_list_checker.sv -----
// ----------------------------------------------------------------------------
// idll_list_checker
// Tracks the linked list from the requests that the block takes in, works out
// head, tail and count after each one, and compares them with every result.
// ----------------------------------------------------------------------------
module idll_list_checker import idll_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [KEY_W-1:0]        i_key,
    input  logic [KEY_W-1:0]        i_anchor_key,
    input  logic                    i_valid,
    input  logic signed [OUT_W-1:0] i_head_key,
    input  logic signed [OUT_W-1:0] i_tail_key,
    input  logic [OUT_W-1:0]        i_element_count,
    output int                      o_mismatches,
    output int                      o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = $clog2(SLOTS);
    localparam logic signed [OUT_W-1:0] NO_LINK = OUT_W'(-1);

    typedef struct {
        logic signed [OUT_W-1:0] head_key;
        logic signed [OUT_W-1:0] tail_key;
        logic [OUT_W-1:0]        element_count;
    } t_list_view;

    logic signed [OUT_W-1:0] prev_of [SLOTS];
    logic signed [OUT_W-1:0] next_of [SLOTS];
    logic signed [OUT_W-1:0] first_key;
    logic signed [OUT_W-1:0] last_key;
    logic [OUT_W-1:0]        elem_count;
    t_list_view              expected_views [$];
    int                      mismatch_count;

    function automatic bit slot_ok(logic signed [OUT_W-1:0] k);
        return (k >= 0) && (k < SLOTS);
    endfunction

    function automatic logic signed [OUT_W-1:0] prev_at(logic signed [OUT_W-1:0] k);
        return slot_ok(k) ? prev_of[AW'(k)] : NO_LINK;
    endfunction

    function automatic logic signed [OUT_W-1:0] next_at(logic signed [OUT_W-1:0] k);
        return slot_ok(k) ? next_of[AW'(k)] : NO_LINK;
    endfunction

    task automatic set_prev(logic signed [OUT_W-1:0] k, logic signed [OUT_W-1:0] v);
        if (slot_ok(k)) prev_of[AW'(k)] = v;
    endtask

    task automatic set_next(logic signed [OUT_W-1:0] k, logic signed [OUT_W-1:0] v);
        if (slot_ok(k)) next_of[AW'(k)] = v;
    endtask

    task automatic count_up();
        if (elem_count < SLOTS) elem_count = elem_count + 1'b1;
    endtask

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // apply one request to the tracked list and queue the view it leaves
    task automatic step_list(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                             logic [KEY_W-1:0] anchor);
        logic signed [OUT_W-1:0] k;
        logic signed [OUT_W-1:0] a;
        logic signed [OUT_W-1:0] p;
        logic signed [OUT_W-1:0] n;
        bit                      key_ok;
        bit                      anc_ok;
        t_list_view              view;
        k      = {1'b0, key};
        a      = {1'b0, anchor};
        key_ok = int'(key) < SLOTS;
        anc_ok = int'(anchor) < SLOTS;
        case (func)
            FUNC_APPEND: begin
                if (key_ok) begin
                    if (last_key == NO_LINK) begin
                        first_key = k;
                        last_key  = k;
                        set_prev(k, NO_LINK);
                        set_next(k, NO_LINK);
                    end else begin
                        set_next(last_key, k);
                        set_prev(k, last_key);
                        set_next(k, NO_LINK);
                        last_key = k;
                    end
                    count_up();
                end
            end
            FUNC_PREPEND: begin
                if (key_ok) begin
                    if (first_key == NO_LINK) begin
                        first_key = k;
                        last_key  = k;
                        set_prev(k, NO_LINK);
                        set_next(k, NO_LINK);
                    end else begin
                        set_next(k, first_key);
                        set_prev(first_key, k);
                        set_prev(k, NO_LINK);
                        first_key = k;
                    end
                    count_up();
                end
            end
            FUNC_BEFORE: begin
                if (key_ok && anc_ok) begin
                    p = prev_at(a);
                    set_prev(k, p);
                    set_next(k, a);
                    set_prev(a, k);
                    if (p != NO_LINK) set_next(p, k);
                    else first_key = k;
                    count_up();
                end
            end
            FUNC_AFTER: begin
                if (key_ok && anc_ok) begin
                    n = next_at(a);
                    set_prev(k, a);
                    set_next(k, n);
                    set_next(a, k);
                    if (n != NO_LINK) set_prev(n, k);
                    else last_key = k;
                    count_up();
                end
            end
            FUNC_REMOVE: begin
                if (key_ok) begin
                    p = prev_at(k);
                    n = next_at(k);
                    if (p == NO_LINK) begin
                        if (n == NO_LINK) begin
                            first_key = NO_LINK;
                            last_key  = NO_LINK;
                        end else begin
                            first_key = n;
                            set_prev(n, NO_LINK);
                        end
                    end else begin
                        if (n == NO_LINK) begin
                            set_next(p, NO_LINK);
                            last_key = p;
                        end else begin
                            set_prev(n, p);
                            set_next(p, n);
                        end
                    end
                    if (elem_count > 0) elem_count = elem_count - 1'b1;
                end
            end
            FUNC_CLEAR: begin
                // links are left stale on purpose
                first_key  = NO_LINK;
                last_key   = NO_LINK;
                elem_count = '0;
            end
            default: ;
        endcase
        view.head_key      = first_key;
        view.tail_key      = last_key;
        view.element_count = elem_count;
        expected_views.push_back(view);
    endtask

    always @(posedge i_clk) begin : watch
        t_list_view want;
        if (!i_rst_n) begin
            foreach (prev_of[i]) begin
                prev_of[i] = NO_LINK;
                next_of[i] = NO_LINK;
            end
            first_key  = NO_LINK;
            last_key   = NO_LINK;
            elem_count = '0;
            expected_views.delete();
            mismatch_count = 0;
        end else begin
            // results first: a request taken at this edge cannot answer here
            if (i_valid === 1'b1) begin
                if (expected_views.size() == 0) begin
                    report_mismatch($sformatf("result with no request outstanding: %0d %0d %0d",
                                              i_head_key, i_tail_key, i_element_count));
                end else begin
                    want = expected_views.pop_front();
                    if (i_head_key !== want.head_key)
                        report_mismatch($sformatf("head_key got %0d want %0d",
                                                  i_head_key, want.head_key));
                    if (i_tail_key !== want.tail_key)
                        report_mismatch($sformatf("tail_key got %0d want %0d",
                                                  i_tail_key, want.tail_key));
                    if (i_element_count !== want.element_count)
                        report_mismatch($sformatf("element_count got %0d want %0d",
                                                  i_element_count, want.element_count));
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0)
                step_list(i_func, i_key, i_anchor_key);
        end
        o_mismatches  = mismatch_count;
        o_outstanding = expected_views.size();
    end

endmodule

// ----- tb/indexed_doubly_linked_list_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_tb
// Drives list requests into the block: a directed opening over head, tail,
// middle and stale-link cases, then rounds of mostly well-formed random
// requests with broken ones mixed in.
// A checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_tb import idll_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 740;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    start           = 1'b0;
    logic [FUNC_W-1:0]       i_func          = '0;
    logic [KEY_W-1:0]        i_key           = '0;
    logic [KEY_W-1:0]        i_anchor_key    = '0;
    logic                    busy;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_head_key;
    logic signed [OUT_W-1:0] o_tail_key;
    logic [OUT_W-1:0]        o_element_count;
    int                      mismatches;
    int                      outstanding;

    int sender_idle_pct = 0;
    int random_sent     = 0;
    bit in_list [SLOTS_DEF];
    int members [$];

    indexed_doubly_linked_list #(.SLOTS(SLOTS_DEF)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_key           (i_key),
        .i_anchor_key    (i_anchor_key),
        .o_valid         (o_valid),
        .o_head_key      (o_head_key),
        .o_tail_key      (o_tail_key),
        .o_element_count (o_element_count)
    );

    idll_list_checker #(.SLOTS(SLOTS_DEF)) list_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (i_func),
        .i_key           (i_key),
        .i_anchor_key    (i_anchor_key),
        .i_valid         (o_valid),
        .i_head_key      (o_head_key),
        .i_tail_key      (o_tail_key),
        .i_element_count (o_element_count),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                                logic [KEY_W-1:0] anchor);
        int gap;
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct && gap < 12)
            gap++;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        = 1'b1;
        i_func       = func;
        i_key        = key;
        i_anchor_key = anchor;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic forget_all();
        members.delete();
        foreach (in_list[i]) in_list[i] = 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] absent_key();
        logic [KEY_W-1:0] k;
        do k = KEY_W'($urandom_range(0, SLOTS_DEF - 1)); while (in_list[k]);
        return k;
    endfunction

    task automatic add_member(logic [KEY_W-1:0] k);
        in_list[k] = 1'b1;
        members.push_back(int'(k));
    endtask

    // one request that keeps the list consistent
    task automatic send_tidy_request();
        int               choice;
        int               idx;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] a;
        choice = $urandom_range(0, 9);
        if (members.size() == 0) choice = $urandom_range(0, 3);
        else if (members.size() > 30 && choice < 5) choice = 9;
        idx = (members.size() > 0) ? $urandom_range(0, members.size() - 1) : 0;
        a   = (members.size() > 0) ? KEY_W'(members[idx])
                                   : KEY_W'($urandom_range(0, SLOTS_DEF - 1));
        case (choice)
            0, 1: begin
                k = absent_key();
                send_request(FUNC_APPEND, k, KEY_W'($urandom_range(0, SLOTS_DEF - 1)));
                add_member(k);
            end
            2, 3: begin
                k = absent_key();
                send_request(FUNC_PREPEND, k, KEY_W'($urandom_range(0, SLOTS_DEF - 1)));
                add_member(k);
            end
            4, 5: begin
                k = absent_key();
                send_request(FUNC_BEFORE, k, a);
                add_member(k);
            end
            6, 7: begin
                k = absent_key();
                send_request(FUNC_AFTER, k, a);
                add_member(k);
            end
            default: begin
                send_request(FUNC_REMOVE, a, KEY_W'($urandom_range(0, SLOTS_DEF - 1)));
                in_list[a] = 1'b0;
                members.delete(idx);
            end
        endcase
    endtask

    // anything at all, often reusing present keys to break the list
    task automatic send_noise_request();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] a;
        k = KEY_W'($urandom_range(0, SLOTS_DEF - 1));
        a = KEY_W'($urandom_range(0, SLOTS_DEF - 1));
        if (members.size() > 0 && $urandom_range(1))
            k = KEY_W'(members[$urandom_range(0, members.size() - 1)]);
        if (members.size() > 0 && $urandom_range(1))
            a = KEY_W'(members[$urandom_range(0, members.size() - 1)]);
        send_request(FUNC_W'($urandom_range(0, 7)), k, a);
    endtask

    initial begin : stimulus
        int round_len;
        bit tidy;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed opening
        send_request(FUNC_REMOVE,   10'd5,    10'd0);    // count stays at zero
        send_request(FUNC_SPARE_LO, 10'd1023, 10'd1023);
        send_request(FUNC_SPARE_HI, 10'd0,    10'd0);
        send_request(FUNC_APPEND,   10'd0,    10'd1023);
        send_request(FUNC_APPEND,   10'd1023, 10'd0);
        send_request(FUNC_PREPEND,  10'd512,  10'd0);
        send_request(FUNC_BEFORE,   10'd341,  10'd1023);
        send_request(FUNC_AFTER,    10'd682,  10'd0);
        send_request(FUNC_BEFORE,   10'd100,  10'd512);  // new head
        send_request(FUNC_AFTER,    10'd900,  10'd1023); // new tail
        send_request(FUNC_REMOVE,   10'd100,  10'd0);
        send_request(FUNC_REMOVE,   10'd900,  10'd0);
        send_request(FUNC_REMOVE,   10'd341,  10'd0);
        send_request(FUNC_APPEND,   10'd0,    10'd0);    // already present
        send_request(FUNC_REMOVE,   10'd777,  10'd0);    // not present
        send_request(FUNC_AFTER,    10'd3,    10'd555);  // anchor not present
        send_request(FUNC_CLEAR,    10'd0,    10'd0);
        send_request(FUNC_BEFORE,   10'd42,   10'd341);  // anchor with stale links
        send_request(FUNC_REMOVE,   10'd42,   10'd0);
        send_request(FUNC_REMOVE,   10'd42,   10'd0);
        send_request(FUNC_PREPEND,  10'd1,    10'd1023);
        send_request(FUNC_AFTER,    10'd2,    10'd1);
        send_request(FUNC_BEFORE,   10'd1022, 10'd1);
        send_request(FUNC_CLEAR,    10'd1023, 10'd1023);

        // random rounds, each opened by a clear so the shadow list is in step
        while (random_sent < RANDOM_REQUESTS) begin
            if (random_sent < RANDOM_REQUESTS / 4)          sender_idle_pct = 0;
            else if (random_sent < RANDOM_REQUESTS / 2)     sender_idle_pct = 53;
            else if (random_sent < 3 * RANDOM_REQUESTS / 4) sender_idle_pct = 0;
            else                                            sender_idle_pct = 20;
            send_request(FUNC_CLEAR, KEY_W'($urandom_range(0, SLOTS_DEF - 1)),
                         KEY_W'($urandom_range(0, SLOTS_DEF - 1)));
            forget_all();
            round_len = $urandom_range(5, 40);
            tidy      = 1'b1;
            repeat (round_len) begin
                if (tidy && $urandom_range(99) < 3) tidy = 1'b0;
                if (tidy) send_tidy_request();
                else      send_noise_request();
                random_sent++;
            end
        end

        start = 1'b0;
        wait (outstanding == 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
